[rtl/nmea_sentence_frame_checker_assert.svh]
// Assertion helpers for the NMEA frame checker.
`ifndef NMEA_SENTENCE_FRAME_CHECKER_ASSERT_SVH
`define NMEA_SENTENCE_FRAME_CHECKER_ASSERT_SVH

// same-cycle implication
`define NMEAFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NMEAFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/nmeafc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package nmeafc_pkg;

  localparam int unsigned MAX_FIELDS = 255;
  localparam int unsigned FIELD_LIMIT = (MAX_FIELDS > 255) ? 255 : MAX_FIELDS;
  localparam logic [7:0] COMMA_MAX = 8'(FIELD_LIMIT - 1);

  localparam int unsigned TAG_COUNT = 13;
  localparam int unsigned TAG_IDX_W = $clog2(TAG_COUNT);

  localparam logic [23:0] TAG_TABLE [TAG_COUNT] = '{
    24'h444254, // DBT
    24'h445054, // DPT
    24'h474741, // GGA
    24'h474C4C, // GLL
    24'h475341, // GSA
    24'h475356, // GSV
    24'h484447, // HDG
    24'h4D5457, // MTW
    24'h4D5756, // MWV
    24'h524D42, // RMB
    24'h524D43, // RMC
    24'h525445, // RTE
    24'h565447  // VTG
  };

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_START  = 3'd1;
  localparam logic [2:0] ST_BAD_FMT   = 3'd2;
  localparam logic [2:0] ST_CSUM_ERR  = 3'd3;
  localparam logic [2:0] ST_SHORT     = 3'd4;

  localparam logic [1:0] HEX_NONE  = 2'd0;
  localparam logic [1:0] HEX_BAD   = 2'd1;
  localparam logic [1:0] HEX_ONE   = 2'd2;
  localparam logic [1:0] HEX_TWO   = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        unknown_tag;
    logic [15:0] talker_id;
    logic [3:0]  tag_index;
    logic [7:0]  computed_checksum;
    logic [7:0]  field_count;
  } out_req_t;

  typedef struct packed {
    logic                 hit;
    logic [TAG_IDX_W-1:0] index;
  } tag_match_t;

endpackage

`default_nettype wire

[rtl/nmea_sentence_frame_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// NMEA sentence frame checker.
// Input channel (in_valid_i / in_stall_o / in_req_i): one sentence byte per
// request, last_byte set on the final byte of a sentence.
// Output channel (out_valid_o / out_stall_i / out_req_o): one request per
// sentence, issued for its final byte, carrying status, talker, tag index,
// computed checksum and field count.
// Each byte goes through an input register and then a single pass of
// combinational logic into the sentence state and the result register.
// A final byte's result is written to the result register as the byte leaves the input register.
// Throughput: one byte per cycle while the input side is not stalled, set by the single update pass.
// The input side stalls only while the input register holds a final byte
// and the result register is full and stalled; non-final bytes keep
// flowing under an output stall.
// Reset clears the sentence state and both valid flags; the block is ready
// as soon as reset is released.

module nmea_sentence_frame_checker (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire nmeafc_pkg::in_req_t  in_req_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output nmeafc_pkg::out_req_t      out_req_o
);

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= "0" && c <= "9") begin
      t = c - 8'h30;
      return {1'b1, t[3:0]};
    end else if (c >= "a" && c <= "f") begin
      t = c - 8'h57;
      return {1'b1, t[3:0]};
    end else if (c >= "A" && c <= "F") begin
      t = c - 8'h37;
      return {1'b1, t[3:0]};
    end
    return 5'b0_0000;
  endfunction

  // input register
  logic                 in_valid_q;
  nmeafc_pkg::in_req_t  in_q;
  logic                 advance;

  // sentence state
  logic [2:0]  pos_q, pos_d;
  logic        start_q, start_d;
  logic        star_q, star_d;
  logic [2:0]  star_pos_q, star_pos_d;
  logic [1:0]  after_q, after_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  hexv_q, hexv_d;
  logic [1:0]  hexs_q, hexs_d;
  logic [15:0] talker_q, talker_d;
  logic [23:0] tag_q, tag_d;
  logic [7:0]  comma_q, comma_d;

  // result register
  logic                  out_valid_q;
  nmeafc_pkg::out_req_t  out_q, out_d;

  nmeafc_pkg::tag_match_t tag_match;
  logic [7:0] b;
  logic [4:0] hd;

  assign advance    = in_valid_q && (!in_q.last_byte || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_req_i;
    end
  end

  assign b  = in_q.data_byte;
  assign hd = hex_decode(b);

  always_comb begin
    start_d    = start_q;
    star_d     = star_q;
    star_pos_d = star_pos_q;
    after_d    = after_q;
    xor_d      = xor_q;
    hexv_d     = hexv_q;
    hexs_d     = hexs_q;
    talker_d   = talker_q;
    tag_d      = tag_q;
    comma_d    = comma_q;
    pos_d      = (pos_q != 3'd7) ? pos_q + 3'd1 : pos_q;

    if (pos_q == 3'd0) begin
      start_d = (b == "$");
    end else if (!star_q) begin
      if (b == "*") begin
        star_d     = 1'b1;
        star_pos_d = pos_q;
      end else begin
        xor_d = xor_q ^ b;
        case (pos_q)
          3'd1: talker_d[15:8] = b;
          3'd2: talker_d[7:0]  = b;
          3'd3: tag_d[23:16]   = b;
          3'd4: tag_d[15:8]    = b;
          3'd5: tag_d[7:0]     = b;
          3'd7: begin
            if (b == "," && comma_q < nmeafc_pkg::COMMA_MAX) begin
              comma_d = comma_q + 8'd1;
            end
          end
          default: ;
        endcase
      end
    end else begin
      if (after_q == 2'd0) begin
        if (!hd[4]) begin
          hexs_d = nmeafc_pkg::HEX_BAD;
        end else begin
          hexs_d = nmeafc_pkg::HEX_ONE;
          hexv_d = {4'h0, hd[3:0]};
        end
      end else if (after_q == 2'd1) begin
        if (hexs_q == nmeafc_pkg::HEX_ONE && hd[4]) begin
          hexv_d = {hexv_q[3:0], hd[3:0]};
          hexs_d = nmeafc_pkg::HEX_TWO;
        end
      end
      if (after_q != 2'd3) begin
        after_d = after_q + 2'd1;
      end
    end
  end

  nmeafc_tag_match u_tag_match (
    .tag_i   (tag_d),
    .match_o (tag_match)
  );

  always_comb begin
    out_d = '0;
    if (!start_d) begin
      out_d.status = nmeafc_pkg::ST_NO_START;
    end else if (!star_d || after_d != 2'd2 || hexs_d == nmeafc_pkg::HEX_NONE
                 || hexs_d == nmeafc_pkg::HEX_BAD) begin
      out_d.status = nmeafc_pkg::ST_BAD_FMT;
    end else if (xor_d != hexv_d) begin
      out_d.status            = nmeafc_pkg::ST_CSUM_ERR;
      out_d.computed_checksum = xor_d;
    end else if (star_pos_d != 3'd7) begin
      out_d.status            = nmeafc_pkg::ST_SHORT;
      out_d.computed_checksum = xor_d;
    end else begin
      // checksum field is reported only with a checksum or length error
      out_d.status            = nmeafc_pkg::ST_OK;
      out_d.talker_id         = talker_d;
      out_d.field_count       = comma_d + 8'd1;
      out_d.unknown_tag       = !tag_match.hit;
      out_d.tag_index         = tag_match.index;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      start_q    <= 1'b0;
      star_q     <= 1'b0;
      star_pos_q <= '0;
      after_q    <= '0;
      xor_q      <= '0;
      hexv_q     <= '0;
      hexs_q     <= nmeafc_pkg::HEX_NONE;
      talker_q   <= '0;
      tag_q      <= '0;
      comma_q    <= '0;
    end else if (advance) begin
      if (in_q.last_byte) begin
        pos_q      <= '0;
        start_q    <= 1'b0;
        star_q     <= 1'b0;
        star_pos_q <= '0;
        after_q    <= '0;
        xor_q      <= '0;
        hexv_q     <= '0;
        hexs_q     <= nmeafc_pkg::HEX_NONE;
        talker_q   <= '0;
        tag_q      <= '0;
        comma_q    <= '0;
      end else begin
        pos_q      <= pos_d;
        start_q    <= start_d;
        star_q     <= star_d;
        star_pos_q <= star_pos_d;
        after_q    <= after_d;
        xor_q      <= xor_d;
        hexv_q     <= hexv_d;
        hexs_q     <= hexs_d;
        talker_q   <= talker_d;
        tag_q      <= tag_d;
        comma_q    <= comma_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_q.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_q.last_byte) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

`include "nmea_sentence_frame_checker_assert.svh"

  `NMEAFC_ASSERT_IMP(a_err_fields_clear, out_valid_q && out_q.status != nmeafc_pkg::ST_OK, out_q.unknown_tag == 1'b0 && out_q.talker_id == 16'h0 && out_q.field_count == 8'h0, "error result carries sentence fields")
  `NMEAFC_ASSERT_IMP(a_ok_fields_nonzero, out_valid_q && out_q.status == nmeafc_pkg::ST_OK, out_q.field_count != 8'h0, "ok result with zero field count")
  `NMEAFC_ASSERT_IMP(a_unknown_idx_zero, out_valid_q && out_q.unknown_tag, out_q.tag_index == '0, "unknown tag with nonzero index")
  `NMEAFC_ASSERT_NXT(a_state_cleared, advance && in_q.last_byte, pos_q == 3'd0 && !star_q && xor_q == 8'h0 && comma_q == 8'h0, "sentence state not cleared after final byte")

endmodule

`default_nettype wire

[rtl/nmeafc_tag_match.sv]
`timescale 1ns / 1ps
`default_nettype none

module nmeafc_tag_match (
  input  wire logic [23:0]            tag_i,
  output nmeafc_pkg::tag_match_t      match_o
);

  always_comb begin
    match_o = '0;
    for (int i = nmeafc_pkg::TAG_COUNT - 1; i >= 0; i--) begin
      if (tag_i == nmeafc_pkg::TAG_TABLE[i]) begin
        match_o.hit   = 1'b1;
        match_o.index = nmeafc_pkg::TAG_IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire
